>>> hw/rtl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
// No dependencies; fpa_front, fpa_back and the top level import it.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int XLEN           = 32;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
        OP_LT   = 4'd4,  OP_LE   = 4'd5,  OP_GT   = 4'd6,  OP_GE   = 4'd7,
        OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_MIN  = 4'd10, OP_MAX  = 4'd11,
        OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FINT = 4'd14, OP_TINT = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    // Classified item: operands and simple results are sign-extended to XLEN
    typedef struct packed {
        t_kind             kind;
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        logic [XLEN-1:0]   val;
        logic              cmp;
    } t_job;

    typedef struct packed {
        logic [XLEN-1:0]   val;
        logic              cmp;
        logic              dz;
    } t_res;

endpackage

>>> hw/rtl/fpa_fifo.sv
// Small flop-based queue, used between front and back and at the output.
// Depends on nothing.
`timescale 1ns / 1ps

module fpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hw/rtl/fpa_front.sv
// Front end: decodes the opcode, finishes the simple operations and
// classifies multiply and divide for the back end. Uses fpa_pkg.
`timescale 1ns / 1ps

module fpa_front #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic [3:0]                 i_opcode,
    input  logic [fpa_pkg::XLEN-1:0]   i_operand_a,
    input  logic [fpa_pkg::XLEN-1:0]   i_operand_b,
    output fpa_pkg::t_job              o_job
);
    import fpa_pkg::*;

    logic signed [DATA_WIDTH-1:0] a, b, v;
    t_opcode                      op;
    logic                         cmp;
    t_kind                        kind;

    assign a  = i_operand_a[DATA_WIDTH-1:0];
    assign b  = i_operand_b[DATA_WIDTH-1:0];
    assign op = t_opcode'(i_opcode);

    always_comb begin
        v    = '0;
        cmp  = 1'b0;
        kind = K_SIMPLE;
        case (op)
            OP_ADD:  v = a + b;
            OP_SUB:  v = a - b;
            OP_MUL:  kind = K_MUL;
            OP_DIV:  kind = K_DIV;
            OP_LT:   cmp = (a < b);
            OP_LE:   cmp = (a <= b);
            OP_GT:   cmp = (a > b);
            OP_GE:   cmp = (a >= b);
            OP_EQ:   cmp = (a == b);
            OP_NE:   cmp = (a != b);
            OP_MIN:  v = (a <= b) ? a : b;
            OP_MAX:  v = (a >= b) ? a : b;
            OP_INC:  v = a + DATA_WIDTH'(1);
            OP_DEC:  v = a - DATA_WIDTH'(1);
            OP_FINT: v = a <<< FRAC_BITS;
            OP_TINT: v = a >>> FRAC_BITS;
            default: v = '0;
        endcase
    end

    assign o_job.kind = kind;
    assign o_job.a    = XLEN'(a);
    assign o_job.b    = XLEN'(b);
    assign o_job.val  = XLEN'(v);
    assign o_job.cmp  = cmp;

endmodule

>>> hw/rtl/fpa_back.sv
// Back end: pipelined multiplier and restoring divider, one quotient bit per
// stage, then rounding. Whole pipeline advances together. Uses fpa_pkg.
`timescale 1ns / 1ps

module fpa_back #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_vld,
    input  fpa_pkg::t_job  i_job,
    output logic           o_take,
    input  logic           i_out_full,
    output logic           o_push,
    output fpa_pkg::t_res  o_res
);
    import fpa_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int NW = DATA_WIDTH + FRAC_BITS;

    logic en;
    assign en     = !i_out_full;
    assign o_take = en && i_in_vld;

    // setup stage: magnitudes, sign and full product
    logic                    r0_vld;
    t_kind                   r0_kind;
    logic [XLEN-1:0]         r0_val;
    logic                    r0_cmp, r0_neg, r0_dz;
    logic signed [2*DW-1:0]  r0_prod;
    logic [DW-1:0]           r0_na, r0_nb;
    logic signed [DW-1:0]    ja, jb;

    assign ja = i_job.a[DW-1:0];
    assign jb = i_job.b[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_kind <= i_job.kind;
            r0_val  <= i_job.val;
            r0_cmp  <= i_job.cmp;
            r0_prod <= ja * jb;
            r0_neg  <= ja[DW-1] ^ jb[DW-1];
            r0_dz   <= (jb == '0);
            r0_na   <= ja[DW-1] ? DW'(-ja) : ja;
            r0_nb   <= jb[DW-1] ? DW'(-jb) : jb;
        end
    end

    logic signed [2*DW-1:0] prod_sh;
    assign prod_sh = r0_prod >>> FRAC_BITS;

    // divide stages: s_* feed stage k, r_* are its registers
    logic            s_vld [NW];
    t_kind           s_kind [NW];
    logic [XLEN-1:0] s_val [NW];
    logic            s_cmp [NW], s_neg [NW], s_dz [NW];
    logic [DW-1:0]   s_nb [NW], s_rem [NW];
    logic [NW-1:0]   s_num [NW];

    logic            r_vld [NW];
    t_kind           r_kind [NW];
    logic [XLEN-1:0] r_val [NW];
    logic            r_cmp [NW], r_neg [NW], r_dz [NW];
    logic [DW-1:0]   r_nb [NW], r_rem [NW];
    logic [NW-1:0]   r_num [NW];

    assign s_vld[0]  = r0_vld;
    assign s_kind[0] = r0_kind;
    assign s_val[0]  = (r0_kind == K_MUL)
                       ? XLEN'($signed(prod_sh[DW-1:0])) : r0_val;
    assign s_cmp[0]  = r0_cmp;
    assign s_neg[0]  = r0_neg;
    assign s_dz[0]   = r0_dz;
    assign s_nb[0]   = r0_nb;
    assign s_rem[0]  = '0;
    assign s_num[0]  = {r0_na, {FRAC_BITS{1'b0}}};

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [DW:0] trial;
        logic        qbit;

        if (k > 0) begin : g_link
            assign s_vld[k]  = r_vld[k-1];
            assign s_kind[k] = r_kind[k-1];
            assign s_val[k]  = r_val[k-1];
            assign s_cmp[k]  = r_cmp[k-1];
            assign s_neg[k]  = r_neg[k-1];
            assign s_dz[k]   = r_dz[k-1];
            assign s_nb[k]   = r_nb[k-1];
            assign s_rem[k]  = r_rem[k-1];
            assign s_num[k]  = r_num[k-1];
        end

        assign trial = {s_rem[k], s_num[k][NW-1]};
        assign qbit  = (trial >= {1'b0, s_nb[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_kind[k] <= s_kind[k];
                r_val[k]  <= s_val[k];
                r_cmp[k]  <= s_cmp[k];
                r_neg[k]  <= s_neg[k];
                r_dz[k]   <= s_dz[k];
                r_nb[k]   <= s_nb[k];
                r_rem[k]  <= qbit ? DW'(trial - {1'b0, s_nb[k]}) : trial[DW-1:0];
                // shift the quotient bit in as the numerator bit leaves
                r_num[k]  <= {s_num[k][NW-2:0], qbit};
            end
        end
    end

    // rounding stage: half away from zero on the magnitude
    logic            rf_vld;
    t_kind           rf_kind;
    logic [XLEN-1:0] rf_val;
    logic            rf_cmp, rf_neg, rf_dz;
    logic [NW-1:0]   rf_q;
    logic            rnd_up;

    assign rnd_up = ({r_rem[NW-1], 1'b0} >= {1'b0, r_nb[NW-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_vld <= 1'b0;
        end else if (en) begin
            rf_vld <= r_vld[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rf_kind <= r_kind[NW-1];
            rf_val  <= r_val[NW-1];
            rf_cmp  <= r_cmp[NW-1];
            rf_neg  <= r_neg[NW-1];
            rf_dz   <= r_dz[NW-1];
            rf_q    <= r_num[NW-1] + NW'(rnd_up);
        end
    end

    logic signed [DW-1:0] quo;
    logic                 is_div;

    assign quo    = rf_neg ? DW'(-rf_q) : rf_q[DW-1:0];
    assign is_div = (rf_kind == K_DIV);
    assign o_push = en && rf_vld;

    always_comb begin
        o_res.cmp = rf_cmp;
        o_res.dz  = is_div && rf_dz;
        if (!is_div) begin
            o_res.val = rf_val;
        end else if (rf_dz) begin
            o_res.val = '0;
        end else begin
            o_res.val = XLEN'(quo);
        end
    end

endmodule

>>> hw/rtl/fixed_point_alu_q24_8.sv
// Signed fixed-point ALU (Q24.8 by default). Push items into the input
// queue; results come out of the output queue in order, one per item. The
// unit takes one item per clock while the output queue is not full; every
// item passes the same pipeline (setup stage, divide stages with one quotient
// bit per stage, rounding stage), whose depth is set by the divider. A full
// output queue stalls the whole pipeline.
// Uses fpa_pkg, fpa_fifo, fpa_front and fpa_back.
`timescale 1ns / 1ps

module fixed_point_alu_q24_8 #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [3:0]                 i_opcode,
    input  logic [fpa_pkg::XLEN-1:0]   i_operand_a,
    input  logic [fpa_pkg::XLEN-1:0]   i_operand_b,
    output logic                       empty,
    input  logic                       pop,
    output logic [fpa_pkg::XLEN-1:0]   o_result_value,
    output logic                       o_compare_true,
    output logic                       o_divide_by_zero
);
    import fpa_pkg::*;

    t_job  job_in, job_q;
    t_res  res_in, res_q;
    logic  mid_empty, take, out_full, out_push;

    fpa_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_opcode    (i_opcode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_job       (job_in)
    );

    fpa_fifo #(.WIDTH($bits(t_job)), .DEPTH(2)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (job_q),
        .o_empty (mid_empty)
    );

    fpa_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_vld   (!mid_empty),
        .i_job      (job_q),
        .o_take     (take),
        .i_out_full (out_full),
        .o_push     (out_push),
        .o_res      (res_in)
    );

    fpa_fifo #(.WIDTH($bits(t_res)), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_result_value   = res_q.val;
    assign o_compare_true   = res_q.cmp;
    assign o_divide_by_zero = res_q.dz;

`ifndef SYNTH
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_divide_by_zero) |-> (o_result_value == '0))
        else $error("divide by zero result not zero");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_compare_true) |-> (o_result_value == '0 && !o_divide_by_zero))
        else $error("compare result carries a value");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_full |-> !out_push)
        else $error("pipeline pushed into full output queue");
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_full && !pop) |=> out_full)
        else $error("output queue drained without pop");
`endif

endmodule
